/* src/efd_pkg.sv */
package efd_pkg;

  // channel counts of the sensor frame
  localparam int unsigned EXG_CHANNELS_DEF = 8;
  localparam int unsigned IMU_CHANNELS_DEF = 9;

  // depth of the command queue between front and back
  localparam int unsigned CMD_QUEUE_DEPTH = 2;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned USED_W   = 4;
  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned VALUE_W  = 36;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned PROD_W   = 41;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [BYTE_W-1:0]  START_MARKER_RST = 8'hA0;
  localparam logic [BYTE_W-1:0]  END_MARKER_RST   = 8'hC0;
  localparam logic [SCALE_W-1:0] EXG_SCALE_RST    = 24'd666687;
  localparam logic [USED_W-1:0]  EXG_USED_RST     = 4'd8;
  localparam logic [USED_W-1:0]  IMU_USED_RST     = 4'd9;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    KIND_COUNTER = 3'd0,
    KIND_EXG     = 3'd1,
    KIND_LOFF_P  = 3'd2,
    KIND_LOFF_N  = 3'd3,
    KIND_IMU     = 3'd4,
    KIND_BAD_END = 3'd5
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_MARKER = 3'd0,
    CFG_END_MARKER   = 3'd1,
    CFG_EXG_SCALE    = 3'd2,
    CFG_EXG_USED     = 3'd3,
    CFG_IMU_USED     = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RD,
    B_CAP,
    B_MUL,
    B_OUT
  } back_state_e;

  typedef struct packed {
    logic [BYTE_W-1:0]  start_marker;
    logic [BYTE_W-1:0]  end_marker;
    logic [SCALE_W-1:0] exg_scale;
    logic [USED_W-1:0]  exg_used;
    logic [USED_W-1:0]  imu_used;
  } cfg_t;

  // end-of-frame command: bad end byte or a good frame waiting in the store
  typedef struct packed {
    logic              bad;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  // index of the last byte of a field of the given kind
  function automatic logic [1:0] last_byte(kind_e k);
    logic [1:0] r;
    case (k)
      KIND_EXG: r = 2'd1;
      KIND_IMU: r = 2'd3;
      default:  r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

/* src/efd_if.sv */
interface efd_in_if import efd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efd_out_if import efd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [2:0]                kind;
  logic [CHAN_W-1:0]         channel;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (output valid, output kind, output channel, output value, output last,
                  input ready);
  modport sink   (input valid, input kind, input channel, input value, input last,
                  output ready);
endinterface

/* src/efd_ram.sv */
module efd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 55,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/efd_front.sv */
module efd_front import efd_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 55,
  localparam int unsigned AW = $clog2(STORE_DEPTH),
  localparam int unsigned PW = $clog2(STORE_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  efd_in_if.sink            rx,
  input  cfg_t              cfg_i,
  output logic              ram_we_o,
  output logic [AW-1:0]     ram_waddr_o,
  output logic [BYTE_W-1:0] ram_wdata_o,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output cmd_t              push_cmd_o,
  input  logic              done_i
);

  logic          in_frame_q, in_frame_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          lock_q, lock_d;
  logic          at_end;
  logic          accept;

  assign at_end = (pos_q == PW'(STORE_DEPTH));

  // store is held by the back end from a good end byte until its run is out
  assign rx.ready = !(in_frame_q && ((!at_end && lock_q) || (at_end && !push_ready_i)));
  assign accept   = rx.valid && rx.ready;

  assign ram_we_o    = accept && in_frame_q && !at_end;
  assign ram_waddr_o = pos_q[AW-1:0];
  assign ram_wdata_o = rx.rx_byte;

  assign push_valid_o    = accept && in_frame_q && at_end;
  assign push_cmd_o.bad  = (rx.rx_byte != cfg_i.end_marker);
  assign push_cmd_o.data = rx.rx_byte;

  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    lock_d     = lock_q;
    if (done_i) begin
      lock_d = 1'b0;
    end
    if (accept) begin
      if (!in_frame_q) begin
        if (rx.rx_byte == cfg_i.start_marker) begin
          in_frame_d = 1'b1;
          pos_d      = '0;
        end
      end else if (!at_end) begin
        pos_d = pos_q + PW'(1);
      end else begin
        in_frame_d = 1'b0;
        pos_d      = '0;
        if (!push_cmd_o.bad) begin
          lock_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      lock_q     <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      lock_q     <= lock_d;
    end
  end

endmodule

/* src/efd_queue.sv */
module efd_queue import efd_pkg::*; #(
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1)
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t              mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_QW-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CNT_QW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_QW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

/* src/efd_back.sv */
module efd_back import efd_pkg::*; #(
  parameter int unsigned EXG_CHANNELS = EXG_CHANNELS_DEF,
  parameter int unsigned IMU_CHANNELS = IMU_CHANNELS_DEF,
  parameter int unsigned STORE_DEPTH  = 55,
  localparam int unsigned AW = $clog2(STORE_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  cmd_t              pop_cmd_i,
  output logic              ram_re_o,
  output logic [AW-1:0]     ram_raddr_o,
  input  logic [BYTE_W-1:0] ram_rdata_i,
  output logic              done_o,
  efd_out_if.source         res
);

  localparam logic [AW-1:0] LOFFP_ADDR = AW'(1 + 2 * EXG_CHANNELS);

  back_state_e state_q, state_d;
  kind_e       kind_q, kind_d;
  logic [CHAN_W-1:0] chan_q, chan_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [1:0]        bidx_q, bidx_d;
  logic [WORD_W-1:0] acc_q, acc_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;

  logic                      out_valid_q, out_valid_d;
  kind_e                     out_kind_q, out_kind_d;
  logic [CHAN_W-1:0]         out_chan_q, out_chan_d;
  logic signed [VALUE_W-1:0] out_value_q, out_value_d;
  logic                      out_last_q, out_last_d;

  logic [CNT_W-1:0] ne, ni, chan_nx;
  logic             slot_free, run_last, byte_done, fits;
  logic signed [VALUE_W-1:0] exg_sat;

  assign ne = ({1'b0, cfg_i.exg_used} > CNT_W'(EXG_CHANNELS)) ? CNT_W'(EXG_CHANNELS)
                                                               : {1'b0, cfg_i.exg_used};
  assign ni = ({1'b0, cfg_i.imu_used} > CNT_W'(IMU_CHANNELS)) ? CNT_W'(IMU_CHANNELS)
                                                               : {1'b0, cfg_i.imu_used};
  assign chan_nx   = {1'b0, chan_q} + CNT_W'(1);
  assign slot_free = !out_valid_q || res.ready;
  assign byte_done = (bidx_q == last_byte(kind_q));
  assign run_last  = (kind_q == KIND_BAD_END)
                  || ((kind_q == KIND_LOFF_N) && (ni == '0))
                  || ((kind_q == KIND_IMU) && (chan_nx >= ni));

  // clamp the 41-bit product to the signed result range
  assign fits    = (&prod_q[PROD_W-1:VALUE_W-1]) || !(|prod_q[PROD_W-1:VALUE_W-1]);
  assign exg_sat = fits ? prod_q[VALUE_W-1:0] : (prod_q[PROD_W-1] ? VALUE_MIN : VALUE_MAX);

  assign pop_ready_o = (state_q == B_IDLE);
  assign ram_re_o    = (state_q == B_RD);
  assign ram_raddr_o = addr_q;
  assign done_o      = (state_q == B_OUT) && slot_free && run_last
                    && (kind_q != KIND_BAD_END);

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          state_d = pop_cmd_i.bad ? B_OUT : B_RD;
        end
      end
      B_RD: state_d = B_CAP;
      B_CAP: begin
        if (byte_done) begin
          state_d = (kind_q == KIND_EXG) ? B_MUL : B_OUT;
        end else begin
          state_d = B_RD;
        end
      end
      B_MUL: state_d = B_OUT;
      B_OUT: begin
        if (slot_free) begin
          state_d = run_last ? B_IDLE : B_RD;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    kind_d      = kind_q;
    chan_d      = chan_q;
    addr_d      = addr_q;
    bidx_d      = bidx_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && !res.ready;
    out_kind_d  = out_kind_q;
    out_chan_d  = out_chan_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          chan_d = '0;
          addr_d = '0;
          bidx_d = '0;
          if (pop_cmd_i.bad) begin
            kind_d = KIND_BAD_END;
            acc_d  = {{(WORD_W-BYTE_W){1'b0}}, pop_cmd_i.data};
          end else begin
            kind_d = KIND_COUNTER;
            acc_d  = '0;
          end
        end
      end
      B_CAP: begin
        acc_d[{bidx_q, 3'b000} +: BYTE_W] = ram_rdata_i;
        addr_d = addr_q + AW'(1);
        bidx_d = byte_done ? 2'd0 : bidx_q + 2'd1;
      end
      B_MUL: begin
        prod_d = PROD_W'($signed(acc_q[15:0])) * PROD_W'($signed({1'b0, cfg_i.exg_scale}));
      end
      B_OUT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = kind_q;
          out_chan_d  = chan_q;
          out_value_d = (kind_q == KIND_EXG) ? exg_sat
                                             : {{(VALUE_W-WORD_W){1'b0}}, acc_q};
          out_last_d  = run_last;
          acc_d       = '0;
          case (kind_q)
            KIND_COUNTER: begin
              if (ne != '0) begin
                kind_d = KIND_EXG;
              end else begin
                kind_d = KIND_LOFF_P;
                addr_d = LOFFP_ADDR;
              end
            end
            KIND_EXG: begin
              if (chan_nx < ne) begin
                chan_d = chan_nx[CHAN_W-1:0];
              end else begin
                kind_d = KIND_LOFF_P;
                chan_d = '0;
                addr_d = LOFFP_ADDR;
              end
            end
            KIND_LOFF_P: kind_d = KIND_LOFF_N;
            KIND_LOFF_N: kind_d = KIND_IMU;
            KIND_IMU:    chan_d = chan_nx[CHAN_W-1:0];
            default:     kind_d = kind_q;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    chan_q      <= chan_d;
    addr_q      <= addr_d;
    bidx_q      <= bidx_d;
    acc_q       <= acc_d;
    prod_q      <= prod_d;
    out_kind_q  <= out_kind_d;
    out_chan_q  <= out_chan_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  assign res.valid   = out_valid_q;
  assign res.kind    = out_kind_q;
  assign res.channel = out_chan_q;
  assign res.value   = out_value_q;
  assign res.last    = out_last_q;

endmodule

/* src/exg_imu_frame_deframer_core.sv */
// channel   dir  handshake        payload
// rx_i      in   valid / ready    rx_byte[7:0]
// res_o     out  valid / ready    kind[2:0] channel[3:0] value[35:0] last
// cfg       in   cfg_we_i         cfg_idx_i[2:0] cfg_data_i[23:0]
//
// bytes are taken while hunting and in frame; the end byte is handed to the
// back end through a two-entry command queue
// a result run reads the frame store byte by byte, each through a read and a
// capture state: counter and lead-off results are one byte, exg two followed by
// one multiply stage, imu four; a bad end result reads nothing from the store
// in-frame bytes stall while the previous good run still reads the frame store
// reset clears control state only; the frame store is not cleared
module exg_imu_frame_deframer_core import efd_pkg::*; #(
  parameter int unsigned EXG_CHANNELS = EXG_CHANNELS_DEF,
  parameter int unsigned IMU_CHANNELS = IMU_CHANNELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  efd_in_if.sink                rx_i,
  efd_out_if.source             res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned STORE_DEPTH = 3 + 2 * EXG_CHANNELS + 4 * IMU_CHANNELS;
  localparam int unsigned AW = $clog2(STORE_DEPTH);

  cfg_t cfg_q;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;
  logic              push_valid, push_ready, pop_valid, pop_ready, done;
  cmd_t              push_cmd, pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= START_MARKER_RST;
      cfg_q.end_marker   <= END_MARKER_RST;
      cfg_q.exg_scale    <= EXG_SCALE_RST;
      cfg_q.exg_used     <= EXG_USED_RST;
      cfg_q.imu_used     <= IMU_USED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_START_MARKER: cfg_q.start_marker <= cfg_data_i[BYTE_W-1:0];
        CFG_END_MARKER:   cfg_q.end_marker   <= cfg_data_i[BYTE_W-1:0];
        CFG_EXG_SCALE:    cfg_q.exg_scale    <= cfg_data_i[SCALE_W-1:0];
        CFG_EXG_USED:     cfg_q.exg_used     <= cfg_data_i[USED_W-1:0];
        CFG_IMU_USED:     cfg_q.imu_used     <= cfg_data_i[USED_W-1:0];
        default: ;
      endcase
    end
  end

  efd_front #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx           (rx_i),
    .cfg_i        (cfg_q),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd),
    .done_i       (done)
  );

  efd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  efd_queue #(
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  efd_back #(
    .EXG_CHANNELS (EXG_CHANNELS),
    .IMU_CHANNELS (IMU_CHANNELS),
    .STORE_DEPTH  (STORE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .done_o      (done),
    .res         (res_o)
  );

endmodule

/* src/efd_chk.sv */
module efd_chk import efd_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [2:0]                out_kind_i,
  input logic [CHAN_W-1:0]         out_channel_i,
  input logic signed [VALUE_W-1:0] out_value_i,
  input logic                      out_last_i
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i)
      && $stable(out_channel_i) && $stable(out_value_i) && $stable(out_last_i))
    else $error("result word changed while stalled");

  a_bad_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_BAD_END) |-> out_last_i && (out_channel_i == '0))
    else $error("bad end result not a single closing word");

  a_chan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i != KIND_EXG) && (out_kind_i != KIND_IMU)
      |-> out_channel_i == '0)
    else $error("nonzero channel on a kind without channels");

  // counter and loff positive words never close a run
  a_counter_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((out_kind_i == KIND_COUNTER) || (out_kind_i == KIND_LOFF_P))
      |-> !out_last_i)
    else $error("run closed too early");

endmodule

bind exg_imu_frame_deframer_core efd_chk u_efd_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .out_kind_i    (res_o.kind),
  .out_channel_i (res_o.channel),
  .out_value_i   (res_o.value),
  .out_last_i    (res_o.last)
);
